// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// next-cycle implication, quiet during reset
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/gbm_pkg.sv -----
// shared types, codes and field layout of the gap buffer
`timescale 1ns / 1ps
package gbm_pkg;

   localparam int CAPACITY_DEF     = 4096;
   localparam int MARKER_COUNT_DEF = 16;

   localparam int REQ_W   = 48;
   localparam int RSP_W   = 88;
   localparam int CSR_IW  = 2;
   localparam int CSR_DW  = 13;

   localparam logic [2:0] ACT_INSERT    = 3'd0;
   localparam logic [2:0] ACT_DEL_FWD   = 3'd1;
   localparam logic [2:0] ACT_DEL_BWD   = 3'd2;
   localparam logic [2:0] ACT_SET_MARK  = 3'd3;
   localparam logic [2:0] ACT_READ_MARK = 3'd4;
   localparam logic [2:0] ACT_READ_CHAR = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RO    = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_UNSET = 2'd3;

   localparam logic [CSR_IW-1:0] CSR_READ_ONLY = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_HEAD_CLIP = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_TAIL_CLIP = 2'd2;

   typedef struct packed {
      logic latch;
      logic refuse;
      logic setup;
      logic copy;
      logic mscan;
      logic edit;
      logic dscan;
      logic mark;
      logic rd_issue;
      logic rd_capture;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic ro_edit;
      logic is_edit;
      logic is_mark;
      logic is_rd;
      logic need_move;
      logic copy_done;
      logic scan_last;
      logic del_scan;
      logic out_free;
   } sts_type;

endpackage

// ----- hw/rtl/gbm_ctrl.sv -----
// sequencing state machine of the gap buffer
`timescale 1ns / 1ps
module gbm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  gbm_pkg::sts_type sts,
   output gbm_pkg::cmd_type cmd
);
   import gbm_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_SETUP  = 4'd2;
   localparam logic [3:0] S_COPY   = 4'd3;
   localparam logic [3:0] S_MSCAN  = 4'd4;
   localparam logic [3:0] S_EDIT   = 4'd5;
   localparam logic [3:0] S_DSCAN  = 4'd6;
   localparam logic [3:0] S_MARK   = 4'd7;
   localparam logic [3:0] S_RD     = 4'd8;
   localparam logic [3:0] S_RDW    = 4'd9;
   localparam logic [3:0] S_FIN    = 4'd10;

   logic [3:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.ro_edit) begin
               cmd.refuse = 1'b1;
               state_in   = S_FIN;
            end else if (sts.is_edit) begin
               state_in = S_SETUP;
            end else if (sts.is_mark) begin
               state_in = S_MARK;
            end else if (sts.is_rd) begin
               state_in = S_RD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = sts.need_move ? S_COPY : S_EDIT;
         end
         S_COPY: begin
            cmd.copy = 1'b1;
            if (sts.copy_done) state_in = S_MSCAN;
         end
         S_MSCAN: begin
            cmd.mscan = 1'b1;
            if (sts.scan_last) state_in = S_EDIT;
         end
         S_EDIT: begin
            cmd.edit = 1'b1;
            state_in = sts.del_scan ? S_DSCAN : S_FIN;
         end
         S_DSCAN: begin
            cmd.dscan = 1'b1;
            if (sts.scan_last) state_in = S_FIN;
         end
         S_MARK: begin
            cmd.mark = 1'b1;
            state_in = S_FIN;
         end
         S_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_RDW;
         end
         S_RDW: begin
            cmd.rd_capture = 1'b1;
            state_in       = S_FIN;
         end
         S_FIN: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ----- hw/rtl/gbm_datapath.sv -----
// text store, lengths, marker table and result register of the gap buffer
`timescale 1ns / 1ps
module gbm_datapath #(
   parameter int CAPACITY     = gbm_pkg::CAPACITY_DEF,
   parameter int MARKER_COUNT = gbm_pkg::MARKER_COUNT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [gbm_pkg::REQ_W-1:0]  req_tdata,
   input  logic                       csr_wr_en,
   input  logic [gbm_pkg::CSR_IW-1:0] csr_index,
   input  logic [gbm_pkg::CSR_DW-1:0] csr_wr_data,
   input  gbm_pkg::cmd_type           cmd,
   output gbm_pkg::sts_type           sts,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [gbm_pkg::RSP_W-1:0]  rsp_tdata
);
   import gbm_pkg::*;

   localparam int LW = $clog2(CAPACITY + 2);
   localparam int AW = $clog2(CAPACITY);
   localparam int MW = (MARKER_COUNT > 1) ? $clog2(MARKER_COUNT) : 1;
   localparam int CW = ((LW > 13) ? LW : 13) + 1;

   // configuration
   logic        ro_ff, ro_in;
   logic [12:0] head_ff, head_in, tail_ff, tail_in;
   // latched transaction
   logic [2:0]  act_ff, act_in;
   logic [12:0] pos_ff, pos_in, num_ff, num_in;
   logic [7:0]  chr_ff, chr_in;
   logic [3:0]  idx_ff, idx_in;
   logic        rg_ff, rg_in;
   // buffer state
   logic [LW-1:0] front_ff, front_in, back_ff, back_in;
   logic [31:0]   mcnt_ff, mcnt_in;
   logic [LW-1:0] place_ff [MARKER_COUNT];
   logic [LW-1:0] place_in [MARKER_COUNT];
   logic [MARKER_COUNT-1:0] right_ff, right_in, valid_ff, valid_in, chg_ff, chg_in;
   // gap move
   logic [LW-1:0] newf_ff, newf_in, oldf_ff, oldf_in, gap_ff, gap_in, rem_ff, rem_in;
   logic          bwd_ff, bwd_in, pend_ff, pend_in;
   logic [AW-1:0] src_ff, src_in, dst_ff, dst_in, wdst_ff, wdst_in;
   logic [MW-1:0] ptr_ff, ptr_in;
   // result fields
   logic [1:0]  st_ff, st_in;
   logic [7:0]  co_ff, co_in;
   logic [12:0] po_ff, po_in, dl_ff, dl_in;
   logic        mv_ff, mv_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   // text store
   logic [7:0]    mem [CAPACITY];
   logic [7:0]    rd_q;
   logic          mem_we;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [7:0]    mem_wd;

   logic [CW-1:0] fr, bk, tl, gapc, p, tgt, hc, flim, blim, kf, kb, pc, mp, rd_full;
   logic [CW-1:0] nf, of, g;
   logic          fwd_ok, bwd_ok, is_full, idx_ok, rd_ok, hit_mv, hit_del;

   always_comb begin
      fr   = CW'(front_ff);
      bk   = CW'(back_ff);
      tl   = fr + bk;
      gapc = CW'(CAPACITY) - tl;
      p    = CW'(pos_ff);
      tgt  = (p == '0) ? '0 : (((p - 1'b1) > tl) ? tl : (p - 1'b1));
      hc   = (head_ff == '0) ? CW'(1) : CW'(head_ff);
      fwd_ok = (bk > CW'(tail_ff)) && (num_ff != '0);
      flim   = bk - CW'(tail_ff);
      kf     = (CW'(num_ff) < flim) ? CW'(num_ff) : flim;
      bwd_ok = ((fr + 1'b1) > hc) && (num_ff != '0);
      blim   = fr + 1'b1 - hc;
      kb     = (CW'(num_ff) < blim) ? CW'(num_ff) : blim;
      is_full = (tl == CW'(CAPACITY));
      idx_ok  = ({28'd0, idx_ff} < MARKER_COUNT);
      pc = (p == '0) ? CW'(1) : ((p > tl + 1'b1) ? (tl + 1'b1) : p);
      mp = CW'(place_ff[ptr_ff]);
      rd_ok   = (p != '0) && (p <= tl);
      rd_full = (p <= fr) ? (p - 1'b1) : (p - 1'b1 + gapc);
      nf = CW'(newf_ff);
      of = CW'(oldf_ff);
      g  = CW'(gap_ff);
      if (bwd_ff) begin
         hit_mv = ((mp == nf + 1'b1) && right_ff[ptr_ff]) ||
                  ((mp > nf + 1'b1) && (mp <= of + 1'b1));
      end else begin
         hit_mv = ((mp >= of + 1'b1 + g) && (mp < nf + 1'b1 + g)) ||
                  ((mp == nf + 1'b1 + g) && !right_ff[ptr_ff]);
      end
      hit_mv  = hit_mv && valid_ff[ptr_ff];
      hit_del = valid_ff[ptr_ff] && (mp > fr) && (mp <= fr + gapc);
   end

   always_comb begin
      sts.ro_edit   = ro_ff && (act_ff <= ACT_DEL_BWD);
      sts.is_edit   = (act_ff <= ACT_DEL_BWD);
      sts.is_mark   = (act_ff == ACT_SET_MARK) || (act_ff == ACT_READ_MARK);
      sts.is_rd     = (act_ff == ACT_READ_CHAR);
      sts.need_move = (tgt != fr);
      sts.copy_done = (rem_ff == '0) && !pend_ff;
      sts.scan_last = (ptr_ff == MW'(MARKER_COUNT - 1));
      sts.del_scan  = ((act_ff == ACT_DEL_FWD) && fwd_ok) ||
                      ((act_ff == ACT_DEL_BWD) && bwd_ok);
      sts.out_free  = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      ro_in = ro_ff; head_in = head_ff; tail_in = tail_ff;
      act_in = act_ff; pos_in = pos_ff; num_in = num_ff; chr_in = chr_ff;
      idx_in = idx_ff; rg_in = rg_ff;
      front_in = front_ff; back_in = back_ff; mcnt_in = mcnt_ff;
      place_in = place_ff; right_in = right_ff; valid_in = valid_ff; chg_in = chg_ff;
      newf_in = newf_ff; oldf_in = oldf_ff; gap_in = gap_ff; rem_in = rem_ff;
      bwd_in = bwd_ff; pend_in = pend_ff; src_in = src_ff; dst_in = dst_ff;
      wdst_in = wdst_ff; ptr_in = ptr_ff;
      st_in = st_ff; co_in = co_ff; po_in = po_ff; dl_in = dl_ff; mv_in = mv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we = 1'b0;
      mem_wa = wdst_ff;
      mem_wd = rd_q;
      mem_ra = cmd.copy ? src_ff : AW'(rd_full);

      if (csr_wr_en) begin
         case (csr_index)
            CSR_READ_ONLY: ro_in   = csr_wr_data[0];
            CSR_HEAD_CLIP: head_in = csr_wr_data;
            CSR_TAIL_CLIP: tail_in = csr_wr_data;
            default: ;
         endcase
      end

      if (cmd.latch) begin
         act_in = req_tdata[2:0];
         pos_in = req_tdata[15:3];
         num_in = req_tdata[28:16];
         chr_in = req_tdata[36:29];
         idx_in = req_tdata[40:37];
         rg_in  = req_tdata[41];
         ptr_in = MW'(req_tdata[40:37]);
         st_in = ST_OK; co_in = '0; po_in = '0; dl_in = '0; mv_in = 1'b0;
      end

      if (cmd.refuse) st_in = ST_RO;

      if (cmd.setup) begin
         ptr_in  = '0;
         pend_in = 1'b0;
         if (tgt != fr) begin
            newf_in  = LW'(tgt);
            oldf_in  = front_ff;
            gap_in   = LW'(gapc);
            bwd_in   = (tgt < fr);
            rem_in   = (tgt < fr) ? LW'(fr - tgt) : LW'(tgt - fr);
            src_in   = (tgt < fr) ? AW'(fr - 1'b1) : AW'(fr + gapc);
            dst_in   = (tgt < fr) ? AW'(fr - 1'b1 + gapc) : AW'(fr);
            front_in = LW'(tgt);
            back_in  = LW'(tl - tgt);
         end
      end

      // one byte a cycle: read issued now, written back from the registered read data
      if (cmd.copy) begin
         if (pend_ff) mem_we = 1'b1;
         if (rem_ff != '0) begin
            src_in  = bwd_ff ? (src_ff - 1'b1) : (src_ff + 1'b1);
            dst_in  = bwd_ff ? (dst_ff - 1'b1) : (dst_ff + 1'b1);
            wdst_in = dst_ff;
            pend_in = 1'b1;
            rem_in  = rem_ff - 1'b1;
         end else begin
            pend_in = 1'b0;
         end
      end

      if (cmd.mscan) begin
         if (hit_mv) begin
            place_in[ptr_ff] = bwd_ff ? LW'(mp + g) : LW'(mp - g);
            chg_in[ptr_ff]   = 1'b1;
         end
         ptr_in = ptr_ff + 1'b1;
      end

      if (cmd.edit) begin
         ptr_in = '0;
         case (act_ff)
            ACT_INSERT: begin
               if (is_full) begin
                  st_in = ST_FULL;
               end else begin
                  mem_we   = 1'b1;
                  mem_wa   = AW'(front_ff);
                  mem_wd   = chr_ff;
                  front_in = front_ff + 1'b1;
                  mcnt_in  = mcnt_ff + 1'b1;
               end
            end
            ACT_DEL_FWD: begin
               if (fwd_ok) begin
                  back_in = LW'(bk - kf);
                  mcnt_in = mcnt_ff + 1'b1;
                  dl_in   = kf[12:0];
               end
            end
            ACT_DEL_BWD: begin
               if (bwd_ok) begin
                  front_in = LW'(fr - kb);
                  mcnt_in  = mcnt_ff + 1'b1;
                  dl_in    = kb[12:0];
               end
            end
            default: ;
         endcase
      end

      if (cmd.dscan) begin
         if (hit_del) begin
            place_in[ptr_ff] = right_ff[ptr_ff] ? LW'(fr + 1'b1 + gapc) : LW'(fr + 1'b1);
            chg_in[ptr_ff]   = 1'b1;
         end
         ptr_in = ptr_ff + 1'b1;
      end

      if (cmd.mark) begin
         if (!idx_ok) begin
            st_in = ST_UNSET;
         end else if (act_ff == ACT_SET_MARK) begin
            valid_in[ptr_ff] = 1'b1;
            chg_in[ptr_ff]   = 1'b0;
            right_in[ptr_ff] = rg_ff;
            if ((pc < fr + 1'b1) || (!rg_ff && (pc == fr + 1'b1)))
               place_in[ptr_ff] = LW'(pc);
            else
               place_in[ptr_ff] = LW'(pc + gapc);
            po_in = pc[12:0];
         end else if (!valid_ff[ptr_ff]) begin
            st_in = ST_UNSET;
         end else begin
            po_in = (mp > fr + 1'b1) ? 13'(mp - gapc) : mp[12:0];
            mv_in = chg_ff[ptr_ff];
         end
      end

      if (cmd.rd_capture) co_in = rd_ok ? rd_q : 8'd0;

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, mcnt_ff, tl[12:0], dl_ff, mv_ff, po_ff, co_ff, st_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_q <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ro_ff <= 1'b0; head_ff <= 13'd1; tail_ff <= '0;
         front_ff <= '0; back_ff <= '0; mcnt_ff <= '0;
         right_ff <= '0; valid_ff <= '0; chg_ff <= '0;
         pend_ff <= 1'b0; rem_ff <= '0; ptr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MARKER_COUNT; i++) place_ff[i] <= '0;
      end else begin
         ro_ff <= ro_in; head_ff <= head_in; tail_ff <= tail_in;
         front_ff <= front_in; back_ff <= back_in; mcnt_ff <= mcnt_in;
         right_ff <= right_in; valid_ff <= valid_in; chg_ff <= chg_in;
         pend_ff <= pend_in; rem_ff <= rem_in; ptr_ff <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         place_ff <= place_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in; pos_ff <= pos_in; num_ff <= num_in; chr_ff <= chr_in;
      idx_ff <= idx_in; rg_ff <= rg_in;
      newf_ff <= newf_in; oldf_ff <= oldf_in; gap_ff <= gap_in; bwd_ff <= bwd_in;
      src_ff <= src_in; dst_ff <= dst_in; wdst_ff <= wdst_in;
      st_ff <= st_in; co_ff <= co_in; po_ff <= po_in; dl_ff <= dl_in; mv_ff <= mv_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- hw/rtl/gap_buffer_with_markers_core.sv -----
// Gap buffer text store with a marker table. One transaction is handled at a time.
// Set and read marker transactions go through decode, mark and finish; a read
// char through decode, issue, capture (registered read of the text store) and
// finish; a refused edit or an unused action from decode to finish. An edit goes
// through decode, setup, edit and finish when the gap already sits at the edit
// position. Moving the gap copies each byte in turn (single read and write port
// of the text store), followed by a marker scan over all MARKER_COUNT entries; a
// delete that removes text adds another marker scan. A finished response waits
// in its own register, so the next transaction is taken while it is pending.
// The text store needs no clearing: bytes are only ever read after being written.
`timescale 1ns / 1ps
module gap_buffer_with_markers_core #(
   parameter int CAPACITY     = gbm_pkg::CAPACITY_DEF,
   parameter int MARKER_COUNT = gbm_pkg::MARKER_COUNT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // action[2:0] position[15:3] count[28:16] char_in[36:29]
   // marker_index[40:37] right_gravity[41]
   input  logic [gbm_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // status[1:0] char_out[9:2] position_out[22:10] marker_moved[23]
   // deleted_count[36:24] text_length[49:37] edit_count[81:50]
   output logic [gbm_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                       csr_wr_en,
   input  logic [gbm_pkg::CSR_IW-1:0] csr_index,
   input  logic [gbm_pkg::CSR_DW-1:0] csr_wr_data
);
   import gbm_pkg::*;
`include "assert_macros.svh"

   cmd_type cmd;
   sts_type sts;

   gbm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   gbm_datapath #(
      .CAPACITY     (CAPACITY),
      .MARKER_COUNT (MARKER_COUNT)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)
   `ASSERT_IMPLY(a_err_no_delete, clock, reset, rsp_tvalid && (rsp_tdata[1:0] != ST_OK), rsp_tdata[36:24] == 13'd0)
   `ASSERT_IMPLY(a_finish_free, clock, reset, cmd.finish, !rsp_tvalid || rsp_tready)

endmodule
